// File: src/dap_pkg.sv
// ----------------------------------------------------------------------------
// dap_pkg
// Shared types and constants of the decimal amount parser: word widths,
// character codes, token kinds and the scaling power table.
// ----------------------------------------------------------------------------
package dap_pkg;

    // field widths
    localparam int unsigned CH_W              = 8;
    localparam int unsigned FRAC_W            = 5;
    localparam int unsigned AMOUNT_W          = 64;
    localparam int unsigned DIGIT_W           = 4;
    localparam int unsigned ACC_WIDTH_DEFAULT = 64;

    // fraction register reset value
    localparam logic [FRAC_W-1:0] FRAC_RESET = 5'd12;

    // character codes
    localparam logic [CH_W-1:0] CHR_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CHR_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CHR_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CHR_COMMA = 8'h2C;
    localparam logic [CH_W-1:0] CHR_POINT = 8'h2E;
    localparam logic [CH_W-1:0] CHR_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CHR_NINE  = 8'h39;

    // final scaling: each stage multiplies by up to 10^STEP_DIGITS;
    // 10^MAX_SCALE exceeds a 64-bit accumulator, so larger scales clamp there
    localparam int unsigned       STEP_DIGITS  = 4;
    localparam int unsigned       SCALE_STAGES = 5;
    localparam int unsigned       POW_W        = 14;
    localparam int unsigned       STEP_W       = 3;
    localparam logic [FRAC_W-1:0] MAX_SCALE    = 5'd20;

    // token queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = 2;

    // character classes
    typedef enum logic [2:0] {
        TK_SPACE = 3'd0,
        TK_COMMA = 3'd1,
        TK_POINT = 3'd2,
        TK_DIGIT = 3'd3,
        TK_OTHER = 3'd4,
        TK_END   = 3'd5
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t           kind;
        logic [DIGIT_W-1:0]  digit;
    } token_t;

    // 10^k for one scaling stage
    function automatic logic [POW_W-1:0] pow10_step(input logic [STEP_W-1:0] k);
        logic [POW_W-1:0] p;
        case (k)
            3'd0:    p = 14'd1;
            3'd1:    p = 14'd10;
            3'd2:    p = 14'd100;
            3'd3:    p = 14'd1000;
            3'd4:    p = 14'd10000;
            default: p = 14'd1;
        endcase
        return p;
    endfunction

endpackage

// File: src/dap_ifs.sv
// ----------------------------------------------------------------------------
// dap_ifs
// Valid/ready channels of the decimal amount parser: character words in,
// result words out.
// ----------------------------------------------------------------------------
interface dap_in_if;
    import dap_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            is_end;

    modport source (output valid, output ch, output is_end, input ready);
    modport sink   (input valid, input ch, input is_end, output ready);
endinterface

interface dap_out_if;
    import dap_pkg::*;

    logic                valid;
    logic                ready;
    logic [AMOUNT_W-1:0] amount;
    logic                ok;

    modport source (output valid, output amount, output ok, input ready);
    modport sink   (input valid, input amount, input ok, output ready);
endinterface

// File: src/dap_front.sv
// ----------------------------------------------------------------------------
// dap_front
// Classifies each incoming character word into a token (space, comma,
// point, digit, other, end) for the token queue.
// ----------------------------------------------------------------------------
module dap_front (
    dap_in_if.sink          chars,
    output logic            tok_valid,
    output dap_pkg::token_t tok,
    input  logic            tok_ready
);
    import dap_pkg::*;

    logic [CH_W-1:0] diff;

    // digit value relative to '0'
    assign diff = chars.ch - CHR_ZERO;

    // character class
    always_comb
    begin
        tok.digit = diff[DIGIT_W-1:0];
        if (chars.is_end)
        begin
            tok.kind = TK_END;
        end
        else if (chars.ch == CHR_SPACE || (chars.ch >= CHR_TAB && chars.ch <= CHR_CR))
        begin
            tok.kind = TK_SPACE;
        end
        else if (chars.ch == CHR_COMMA)
        begin
            tok.kind = TK_COMMA;
        end
        else if (chars.ch == CHR_POINT)
        begin
            tok.kind = TK_POINT;
        end
        else if (chars.ch >= CHR_ZERO && chars.ch <= CHR_NINE)
        begin
            tok.kind = TK_DIGIT;
        end
        else
        begin
            tok.kind = TK_OTHER;
        end
    end

    // handshake straight into the queue
    assign tok_valid   = chars.valid;
    assign chars.ready = tok_ready;

endmodule

// File: src/dap_queue.sv
// ----------------------------------------------------------------------------
// dap_queue
// Small token fifo that decouples classification from the parse back end.
// ----------------------------------------------------------------------------
module dap_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    input  dap_pkg::token_t wr_tok,
    output logic            wr_ready,
    output logic            rd_valid,
    output dap_pkg::token_t rd_tok,
    input  logic            rd_ready
);
    import dap_pkg::*;

    token_t              mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;
    logic                do_wr;
    logic                do_rd;

    assign wr_ready = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_tok   = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_tok;
        end
    end

endmodule

// File: src/dap_back.sv
// ----------------------------------------------------------------------------
// dap_back
// Parse state and accumulation per token; on an end token, final scaling
// by 10^(fraction_digits - fraction_count) through a short multiply pipeline
// ending in the result register.
// ----------------------------------------------------------------------------
module dap_back #(
    parameter int unsigned ACC_WIDTH = dap_pkg::ACC_WIDTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        tok_valid,
    input  dap_pkg::token_t             tok,
    output logic                        tok_ready,
    input  logic                        cfg_we,
    input  logic [dap_pkg::FRAC_W-1:0]  cfg_wdata,
    dap_out_if.source                   result
);
    import dap_pkg::*;

    localparam int unsigned NS    = SCALE_STAGES;
    localparam int unsigned MUL_W = ACC_WIDTH + 4;
    localparam int unsigned PRD_W = ACC_WIDTH + POW_W;

    // configuration and parse state
    logic [FRAC_W-1:0]    fd_reg;
    logic [ACC_WIDTH-1:0] acc_reg, acc_next;
    logic                 ovf_reg, ovf_next;
    logic                 point_reg, point_next;
    logic [FRAC_W-1:0]    frac_reg, frac_next;
    logic                 bad_reg, bad_next;
    logic                 started_reg, started_next;
    logic                 gap_reg, gap_next;
    logic                 digit_reg, digit_next;

    // scaling pipeline, stage 0 loaded on an end token
    logic                 vld_reg [NS+1];
    logic [ACC_WIDTH-1:0] val_reg [NS+1];
    logic [FRAC_W-1:0]    rem_reg [NS+1];
    logic                 okf_reg [NS+1];
    logic [ACC_WIDTH-1:0] val_next [NS+1];
    logic [FRAC_W-1:0]    rem_next [NS+1];
    logic                 okf_next [NS+1];

    logic                 pipe_en;
    logic                 consume;
    logic                 end_take;
    logic                 frac_room;
    logic [MUL_W-1:0]     mul_full;
    logic                 mul_ovf;
    logic [FRAC_W-1:0]    scale_n;

    assign pipe_en   = !vld_reg[NS] || result.ready;
    assign tok_ready = (tok.kind != TK_END) || pipe_en;
    assign consume   = tok_valid && tok_ready;
    assign end_take  = consume && (tok.kind == TK_END);
    assign frac_room = (frac_reg < fd_reg);

    // acc * 10 + digit with carry-out bits
    assign mul_full = (MUL_W'(acc_reg) << 3) + (MUL_W'(acc_reg) << 1) + MUL_W'(tok.digit);
    assign mul_ovf  = (mul_full[MUL_W-1:ACC_WIDTH] != '0);

    // remaining scale, clamped where any nonzero value overflows anyway
    assign scale_n = fd_reg - frac_reg;

    // per token state update
    always_comb
    begin
        acc_next     = acc_reg;
        ovf_next     = ovf_reg;
        point_next   = point_reg;
        frac_next    = frac_reg;
        bad_next     = bad_reg;
        started_next = started_reg;
        gap_next     = gap_reg;
        digit_next   = digit_reg;
        if (consume)
        begin
            case (tok.kind)
                TK_END:
                begin
                    acc_next     = '0;
                    ovf_next     = 1'b0;
                    point_next   = 1'b0;
                    frac_next    = '0;
                    bad_next     = 1'b0;
                    started_next = 1'b0;
                    gap_next     = 1'b0;
                    digit_next   = 1'b0;
                end
                TK_SPACE:
                begin
                    if (started_reg)
                    begin
                        gap_next = 1'b1;
                    end
                end
                default:
                begin
                    started_next = 1'b1;
                    if (gap_reg)
                    begin
                        bad_next = 1'b1;
                    end
                    if (tok.kind == TK_POINT)
                    begin
                        if (point_reg)
                        begin
                            bad_next = 1'b1;
                        end
                        point_next = 1'b1;
                    end
                    else if (tok.kind == TK_DIGIT)
                    begin
                        digit_next = 1'b1;
                        if (!point_reg || frac_room)
                        begin
                            if (!ovf_reg)
                            begin
                                if (mul_ovf)
                                begin
                                    ovf_next = 1'b1;
                                end
                                else
                                begin
                                    acc_next = mul_full[ACC_WIDTH-1:0];
                                end
                            end
                            if (point_reg)
                            begin
                                frac_next = frac_reg + 1'b1;
                            end
                        end
                        else if (tok.digit != '0)
                        begin
                            bad_next = 1'b1;
                        end
                    end
                    else if (tok.kind != TK_COMMA)
                    begin
                        bad_next = 1'b1;
                    end
                end
            endcase
        end
    end

    // stage 0 payload from the parse state
    always_comb
    begin
        val_next[0] = acc_reg;
        rem_next[0] = (scale_n > MAX_SCALE) ? MAX_SCALE : scale_n;
        okf_next[0] = !bad_reg && digit_reg && (frac_reg <= fd_reg) && !ovf_reg;
    end

    // scaling stages: multiply by up to 10^STEP_DIGITS each
    for (genvar g = 1; g <= NS; g++)
    begin : g_scale
        logic [STEP_W-1:0] step_k;
        logic [PRD_W-1:0]  prod;

        assign step_k = (rem_reg[g-1] >= FRAC_W'(STEP_DIGITS))
                      ? STEP_W'(STEP_DIGITS) : rem_reg[g-1][STEP_W-1:0];
        assign prod   = PRD_W'(val_reg[g-1]) * PRD_W'(pow10_step(step_k));

        always_comb
        begin
            val_next[g] = prod[ACC_WIDTH-1:0];
            rem_next[g] = rem_reg[g-1] - FRAC_W'(step_k);
            okf_next[g] = okf_reg[g-1] && (prod[PRD_W-1:ACC_WIDTH] == '0);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fd_reg      <= FRAC_RESET;
            acc_reg     <= '0;
            ovf_reg     <= 1'b0;
            point_reg   <= 1'b0;
            frac_reg    <= '0;
            bad_reg     <= 1'b0;
            started_reg <= 1'b0;
            gap_reg     <= 1'b0;
            digit_reg   <= 1'b0;
            for (int i = 0; i <= NS; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                fd_reg <= cfg_wdata;
            end
            acc_reg     <= acc_next;
            ovf_reg     <= ovf_next;
            point_reg   <= point_next;
            frac_reg    <= frac_next;
            bad_reg     <= bad_next;
            started_reg <= started_next;
            gap_reg     <= gap_next;
            digit_reg   <= digit_next;
            if (pipe_en)
            begin
                vld_reg[0] <= end_take;
                for (int i = 1; i <= NS; i++)
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int i = 0; i <= NS; i++)
            begin
                val_reg[i] <= val_next[i];
                rem_reg[i] <= rem_next[i];
                okf_reg[i] <= okf_next[i];
            end
        end
    end

    // result word from the last stage
    assign result.valid  = vld_reg[NS];
    assign result.ok     = okf_reg[NS];
    assign result.amount = okf_reg[NS] ? AMOUNT_W'(val_reg[NS]) : '0;

endmodule

// File: src/decimal_amount_parser.sv
// ----------------------------------------------------------------------------
// decimal_amount_parser
// ASCII amount text in, one character word at a time; fixed-point amount
// scaled by 10^fraction_digits plus an ok flag out on each end word.
// ----------------------------------------------------------------------------
// chars carries one character word per handshake; a word with is_end set
// closes the string and produces exactly one result word, others none.
// cfg_we/cfg_wdata write fraction_digits (reset 12); write only while idle.
// Throughput is one character word per cycle, end words included, while no
// result word is held waiting on result.ready and the token queue has room.
// An end word passes through the four-entry token queue and the parse stage,
// which loads scaling stage 0, then five 64x14 multiply stages that apply the
// final 10^n scale; the last of them holds the result word.
// When a result word waits with result.ready low the scaling pipeline holds;
// the parse stage keeps taking non-end tokens, and the queue fills, the end
// word included, to four words before chars.ready drops.
// Reset clears the parse state, the queue and the pipeline, and sets
// fraction_digits to 12.
// Failure (bad syntax, no digit, overflow) gives amount 0 with ok low.
// ----------------------------------------------------------------------------
module decimal_amount_parser #(
    parameter int unsigned ACC_WIDTH = dap_pkg::ACC_WIDTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    dap_in_if.sink                     chars,
    dap_out_if.source                  result,
    input  logic                       cfg_we,
    input  logic [dap_pkg::FRAC_W-1:0] cfg_wdata
);
    import dap_pkg::*;

    logic   fr_valid;
    token_t fr_tok;
    logic   fr_ready;
    logic   bk_valid;
    token_t bk_tok;
    logic   bk_ready;

    // classification
    dap_front u_front (
        .chars     (chars),
        .tok_valid (fr_valid),
        .tok       (fr_tok),
        .tok_ready (fr_ready)
    );

    // token queue
    dap_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fr_valid),
        .wr_tok   (fr_tok),
        .wr_ready (fr_ready),
        .rd_valid (bk_valid),
        .rd_tok   (bk_tok),
        .rd_ready (bk_ready)
    );

    // parse and scale
    dap_back #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (bk_valid),
        .tok       (bk_tok),
        .tok_ready (bk_ready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .result    (result)
    );

endmodule
